FILE: rtl/pngenc_pkg.sv
// Shared types, constants and byte tables for the PNG RGBA8 stored-deflate encoder.
// No dependencies; the top module imports this package.
package pngenc_pkg;

   localparam int DIM_BITS = 14;
   localparam logic [14:0] DIM_MAX = 15'(1 << DIM_BITS);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
   localparam logic [7:0]  IEND_CRC_LSB = 8'h82;

   // Last byte index of each emitted section
   localparam logic [5:0] START_LAST = 6'd42;
   localparam logic [5:0] HDR_LAST   = 6'd4;
   localparam logic [5:0] TRAIL_LAST = 6'd19;
   localparam logic [5:0] IHDR_CRC_LAST = 6'd32;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_HDR,
      ST_FILT,
      ST_DATA,
      ST_TRAIL
   } enc_state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Signature, IHDR chunk, IDAT length and type, zlib header
   function automatic logic [7:0] start_byte(input logic [5:0] idx, input logic [14:0] w,
                                             input logic [14:0] h, input logic [31:0] crc,
                                             input logic [31:0] idat);
      logic [31:0] hc;
      logic [7:0]  b;
      hc = ~crc;
      case (idx)
         6'd0:  b = 8'h89;
         6'd1:  b = 8'h50;
         6'd2:  b = 8'h4E;
         6'd3:  b = 8'h47;
         6'd4:  b = 8'h0D;
         6'd5:  b = 8'h0A;
         6'd6:  b = 8'h1A;
         6'd7:  b = 8'h0A;
         6'd11: b = 8'h0D;
         6'd12: b = 8'h49;
         6'd13: b = 8'h48;
         6'd14: b = 8'h44;
         6'd15: b = 8'h52;
         6'd18: b = {1'b0, w[14:8]};
         6'd19: b = w[7:0];
         6'd22: b = {1'b0, h[14:8]};
         6'd23: b = h[7:0];
         6'd24: b = 8'h08;
         6'd25: b = 8'h06;
         6'd29: b = hc[31:24];
         6'd30: b = hc[23:16];
         6'd31: b = hc[15:8];
         6'd32: b = hc[7:0];
         6'd33: b = idat[31:24];
         6'd34: b = idat[23:16];
         6'd35: b = idat[15:8];
         6'd36: b = idat[7:0];
         6'd37: b = 8'h49;
         6'd38: b = 8'h44;
         6'd39: b = 8'h41;
         6'd40: b = 8'h54;
         6'd41: b = 8'h78;
         6'd42: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Adler-32, IDAT CRC, IEND chunk
   function automatic logic [7:0] trail_byte(input logic [5:0] idx, input logic [31:0] adler,
                                             input logic [31:0] crc);
      logic [31:0] dc;
      logic [7:0]  b;
      dc = ~crc;
      case (idx)
         6'd0:  b = adler[31:24];
         6'd1:  b = adler[23:16];
         6'd2:  b = adler[15:8];
         6'd3:  b = adler[7:0];
         6'd4:  b = dc[31:24];
         6'd5:  b = dc[23:16];
         6'd6:  b = dc[15:8];
         6'd7:  b = dc[7:0];
         6'd12: b = 8'h49;
         6'd13: b = 8'h45;
         6'd14: b = 8'h4E;
         6'd15: b = 8'h44;
         6'd16: b = 8'hAE;
         6'd17: b = 8'h42;
         6'd18: b = 8'h60;
         6'd19: b = IEND_CRC_LSB;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/pngenc_req_if.sv
// Input channel: one raw image byte per item, valid/ready handshake.
// Standalone; no package dependency.
interface pngenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/pngenc_rsp_if.sv
// Output channel: one PNG file byte per item with an end-of-file flag.
// Standalone; no package dependency.
interface pngenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       file_end;

   modport source (output valid, output out_byte, output file_end, input ready);
   modport sink   (input valid, input out_byte, input file_end, output ready);
endinterface

FILE: rtl/png_rgba8_stored_encoder_top.sv
// Top level of the streaming PNG encoder (RGBA8, stored deflate blocks).
// Depends on pngenc_pkg, pngenc_req_if and pngenc_rsp_if.
//
//   channel    dir  handshake              payload
//   req_chan   in   valid/ready            data_byte[7:0]
//   rsp_chan   out  valid/ready            out_byte[7:0], file_end
//   csr_*      in   csr_we (no back-press) csr_index[0], csr_wdata[14:0]
//
// Every file byte leaves at one per cycle while rsp_chan is not stalled, from a
// single output register. An item makes one plain image byte, plus a row filter
// byte at a row start, 5 bytes per stored-block header, 43 bytes of file head on
// the first item and 20 bytes of trailer on the last, in the emit sequencer's order.
// The next item is taken in the cycle its predecessor's last byte is emitted.
// Reset is synchronous; width and height return to 1 and req_chan.ready stays low.
// A stalled rsp_chan holds the output register and the sequencer; outside idle,
// req_chan.ready drops with it. Register writes are dropped while a file is open.
module png_rgba8_stored_encoder_top (
   input  logic                  clock,
   input  logic                  reset,
   pngenc_req_if.sink            req_chan,
   pngenc_rsp_if.source          rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [14:0]           csr_wdata
);
   import pngenc_pkg::*;

   // configuration
   logic [14:0] width_ff, height_ff;
   logic [14:0] csr_clamped;

   // file state
   logic        active_ff, active_in;
   logic [16:0] col_ff, col_in;
   logic [14:0] row_ff, row_in;
   logic [15:0] blk_ff, blk_in;
   logic [30:0] scan_ff, scan_in;
   logic [15:0] alo_ff, alo_in, ahi_ff, ahi_in;
   logic [31:0] crc_ff, crc_in;

   // size pipeline, refreshed every cycle from the registers
   logic [30:0] total_ff;
   logic [16:0] blocks_ff;
   logic [31:0] idat_ff;
   logic [31:0] blk_y;
   logic [16:0] blk_s;
   logic [1:0]  blk_q;

   // sequencer
   enc_state_type st_ff, st_in;
   logic [5:0]  idx_ff, idx_in;
   logic        filt_ff, filt_in;
   logic [7:0]  item_ff, item_in;

   // output register
   logic        rsp_vld_ff, rsp_vld_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_end_ff, rsp_end_in;

   logic        adv, emit, last, accept;
   logic [7:0]  emit_byte;
   logic        emit_end;
   logic        scan_step;
   logic [7:0]  scan_val;
   logic [15:0] hdr_len;
   logic [16:0] col_inc;
   logic [14:0] row_inc;
   logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;

   assign adv    = !rsp_vld_ff || rsp_chan.ready;
   assign emit   = (st_ff != ST_IDLE) && adv;
   assign req_chan.ready = !reset && ((st_ff == ST_IDLE) || last);
   assign accept = req_chan.valid && req_chan.ready;
   assign item_in = accept ? req_chan.data_byte : item_ff;

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.file_end = rsp_end_ff;

   assign hdr_len = (scan_ff > 31'(BLOCK_MAX)) ? BLOCK_MAX : scan_ff[15:0];
   assign col_inc = col_ff + 17'd1;
   assign row_inc = row_ff + 15'd1;

   // Adler update for one scanline byte: add, then fold back below the modulus
   assign lo_sum = {1'b0, alo_ff} + {9'd0, scan_val};
   assign lo_mod = (lo_sum >= ADLER_MOD) ? (lo_sum - ADLER_MOD) : lo_sum;
   assign hi_sum = {1'b0, ahi_ff} + lo_mod;
   assign hi_mod = (hi_sum >= ADLER_MOD) ? (hi_sum - ADLER_MOD) : hi_sum;

   // Clamp a dimension write into 1..DIM_MAX
   assign csr_clamped = (csr_wdata == 15'd0) ? 15'd1 :
                        (csr_wdata > DIM_MAX) ? DIM_MAX : csr_wdata;

   // ceil(total / 65535): split y = a*65536 + r = a*65535 + (a + r)
   assign blk_y = {1'b0, total_ff} + 32'd65534;
   assign blk_s = {1'b0, blk_y[31:16]} + {1'b0, blk_y[15:0]};
   assign blk_q = (blk_s >= 17'd131070) ? 2'd2 : (blk_s >= 17'd65535) ? 2'd1 : 2'd0;

   // Byte generation and file state updates
   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      blk_in    = blk_ff;
      scan_in   = scan_ff;
      alo_in    = alo_ff;
      ahi_in    = ahi_ff;
      crc_in    = crc_ff;
      emit_byte = 8'h00;
      emit_end  = 1'b0;
      last      = 1'b0;
      scan_step = 1'b0;
      scan_val  = 8'h00;
      if (emit) begin
         case (st_ff)
            ST_START: begin
               emit_byte = start_byte(idx_ff, width_ff, height_ff, crc_ff, idat_ff);
               // IHDR type+payload and IDAT type+zlib header feed the CRC
               if ((idx_ff >= 6'd12 && idx_ff <= 6'd28) || idx_ff >= 6'd37) begin
                  crc_in = crc_byte(crc_ff, emit_byte);
               end
               if (idx_ff == IHDR_CRC_LAST) begin
                  crc_in = CRC_ONES;
               end
               if (idx_ff == START_LAST) begin
                  scan_in   = total_ff;
                  active_in = 1'b1;
               end
            end
            ST_HDR: begin
               case (idx_ff)
                  6'd0:    emit_byte = (scan_ff <= 31'(BLOCK_MAX)) ? 8'h01 : 8'h00;
                  6'd1:    emit_byte = hdr_len[7:0];
                  6'd2:    emit_byte = hdr_len[15:8];
                  6'd3:    emit_byte = ~hdr_len[7:0];
                  default: emit_byte = ~hdr_len[15:8];
               endcase
               crc_in = crc_byte(crc_ff, emit_byte);
               if (idx_ff == HDR_LAST) begin
                  blk_in = hdr_len;
               end
            end
            ST_FILT: begin
               scan_step = 1'b1;
            end
            ST_DATA: begin
               scan_step = 1'b1;
               scan_val  = item_ff;
               if (col_inc >= {width_ff, 2'b00}) begin
                  col_in = 17'd0;
                  row_in = row_inc;
                  last   = (row_inc < height_ff);
               end else begin
                  col_in = col_inc;
                  last   = 1'b1;
               end
            end
            ST_TRAIL: begin
               emit_byte = trail_byte(idx_ff, {ahi_ff, alo_ff}, crc_ff);
               if (idx_ff < 6'd4) begin
                  crc_in = crc_byte(crc_ff, emit_byte);
               end
               if (idx_ff == TRAIL_LAST) begin
                  // drop back to idle with the file state cleared
                  emit_end  = 1'b1;
                  last      = 1'b1;
                  active_in = 1'b0;
                  col_in    = 17'd0;
                  row_in    = 15'd0;
                  blk_in    = 16'd0;
                  scan_in   = 31'd0;
                  alo_in    = 16'd1;
                  ahi_in    = 16'd0;
                  crc_in    = CRC_ONES;
               end
            end
            default: begin
               emit_byte = 8'h00;
            end
         endcase
         if (scan_step) begin
            emit_byte = scan_val;
            crc_in    = crc_byte(crc_ff, scan_val);
            alo_in    = lo_mod[15:0];
            ahi_in    = hi_mod[15:0];
            blk_in    = (blk_ff != 16'd0) ? (blk_ff - 16'd1) : blk_ff;
            scan_in   = (scan_ff != 31'd0) ? (scan_ff - 31'd1) : scan_ff;
         end
      end
   end

   // Output register: load on emit, clear when taken
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_end_in  = rsp_end_ff;
      if (emit) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = emit_byte;
         rsp_end_in  = emit_end;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Next state of the sequencer
   always_comb begin
      st_in   = st_ff;
      idx_in  = idx_ff;
      filt_in = filt_ff;
      if (emit) begin
         idx_in = idx_ff + 6'd1;
         case (st_ff)
            ST_START: begin
               if (idx_ff == START_LAST) begin
                  st_in  = ST_HDR;
                  idx_in = 6'd0;
               end
            end
            ST_HDR: begin
               if (idx_ff == HDR_LAST) begin
                  st_in  = filt_ff ? ST_FILT : ST_DATA;
                  idx_in = 6'd0;
               end
            end
            ST_FILT: begin
               filt_in = 1'b0;
               st_in   = (blk_in == 16'd0) ? ST_HDR : ST_DATA;
               idx_in  = 6'd0;
            end
            ST_DATA: begin
               if (!last) begin
                  st_in  = ST_TRAIL;
                  idx_in = 6'd0;
               end
            end
            ST_TRAIL: begin
               idx_in = idx_ff + 6'd1;
            end
            default: begin
               st_in = ST_IDLE;
            end
         endcase
      end
      // Dispatch a new item from the state its predecessor leaves behind
      if (accept) begin
         idx_in = 6'd0;
         if (!active_in) begin
            st_in   = ST_START;
            filt_in = 1'b1;
         end else begin
            filt_in = (col_in == 17'd0);
            st_in   = (blk_in == 16'd0) ? ST_HDR :
                      (col_in == 17'd0) ? ST_FILT : ST_DATA;
         end
      end else if (last) begin
         st_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 15'd1;
         height_ff  <= 15'd1;
         active_ff  <= 1'b0;
         col_ff     <= 17'd0;
         row_ff     <= 15'd0;
         blk_ff     <= 16'd0;
         scan_ff    <= 31'd0;
         alo_ff     <= 16'd1;
         ahi_ff     <= 16'd0;
         crc_ff     <= CRC_ONES;
         st_ff      <= ST_IDLE;
         idx_ff     <= 6'd0;
         filt_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // hold configuration from the first item of a file to its last byte
         if (csr_we && !active_ff && (st_ff == ST_IDLE)) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_clamped;
               CSR_HEIGHT: height_ff <= csr_clamped;
               default:    width_ff  <= width_ff;
            endcase
         end
         active_ff  <= active_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         blk_ff     <= blk_in;
         scan_ff    <= scan_in;
         alo_ff     <= alo_in;
         ahi_ff     <= ahi_in;
         crc_ff     <= crc_in;
         st_ff      <= st_in;
         idx_ff     <= idx_in;
         filt_ff    <= filt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      // total scanline bytes, block count, IDAT payload length
      total_ff    <= 31'({17'd0, height_ff} * ({15'd0, width_ff, 2'b00} + 32'd1));
      blocks_ff   <= {1'b0, blk_y[31:16]} + {15'd0, blk_q};
      idat_ff     <= 32'd6 + {13'd0, blocks_ff, 2'b00} + {15'd0, blocks_ff}
                     + {1'b0, total_ff};
   end

`ifndef ASSERT_OFF
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_end_ff |-> rsp_byte_ff == IEND_CRC_LSB)
      else $error("file end flag on a byte other than the IEND CRC tail");

   a_crc_cleared: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> crc_ff == CRC_ONES && alo_ff == 16'd1 && ahi_ff == 16'd0)
      else $error("checksums not cleared at file end");

   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> col_ff == 17'd0 && row_ff == 15'd0)
      else $error("row or column count left over outside a file");

   a_block_in_scan: assert property (@(posedge clock) disable iff (reset)
      {15'd0, blk_ff} <= scan_ff)
      else $error("stored block runs past the scanline data");
`endif

endmodule
